// ----- rtl/ede_pkg.sv -----
// Shared types, constants and helpers of the edit distance engine.
package ede_pkg;

    // Cell value width and saturation point
    localparam int CELL_W = 5;
    localparam logic [CELL_W-1:0] CELL_MAX = 5'd31;

    // Query bytes backed by registers
    localparam int QUERY_CHARS = 20;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LEN  = 2'd3;
    localparam int CFG_DATA_W = 64;

    typedef logic [CELL_W-1:0] t_cell;

    // Input item
    typedef struct packed {
        logic [7:0] candidate_char;
        logic       char_present;
        logic       last_char;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [4:0] distance;
        logic [3:0] candidate_length;
        logic       too_long;
    } t_out_item;

    // Row wavefront handed from cell to cell
    typedef struct packed {
        logic       valid;
        logic       adv;
        logic       last;
        logic       ovf;
        logic [7:0] ch;
        t_cell      left;
        t_cell      diag;
        t_cell      pick;
    } t_token;

    function automatic t_cell sat_inc(input t_cell v);
        return (v == CELL_MAX) ? CELL_MAX : v + t_cell'(1);
    endfunction

endpackage

// ----- rtl/ede_cell.sv -----
// One query column of the edit distance row: holds its cell and updates it per wavefront.
module ede_cell #(
    parameter int COL   = 1,
    parameter int LEN_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ede_pkg::t_token   i_tok,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [7:0]        i_qchar,
    input  logic              i_sel,
    output ede_pkg::t_token   o_tok,
    output logic [LEN_W-1:0]  o_len
);
    import ede_pkg::*;

    t_cell      r_cell;
    t_cell      n_cell;
    t_cell      w_best;
    t_cell      w_new;
    t_cell      w_left;
    t_cell      w_sub;
    t_token     r_tok;
    t_token     n_tok;
    logic [LEN_W-1:0] r_len;

    // Pick the cheapest of delete, insert and substitute; keep the cell when the item carries no character
    always_comb begin
        w_best = sat_inc(r_cell);
        w_left = sat_inc(i_tok.left);
        w_sub  = (i_qchar == i_tok.ch) ? i_tok.diag : sat_inc(i_tok.diag);
        if (w_left < w_best) begin
            w_best = w_left;
        end
        if (w_sub < w_best) begin
            w_best = w_sub;
        end
        w_new = i_tok.adv ? w_best : r_cell;
    end

    // Build the outgoing wavefront and the next cell value
    always_comb begin
        n_tok       = i_tok;
        n_tok.left  = w_new;
        n_tok.diag  = r_cell;
        n_tok.pick  = i_sel ? w_new : i_tok.pick;
        n_cell      = r_cell;
        if (i_tok.valid) begin
            if (i_tok.last) begin
                n_cell = CELL_W'(COL);
            end else begin
                n_cell = w_new;
            end
        end
    end

    // Advance cell and wavefront together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell      <= CELL_W'(COL);
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
            r_tok  <= n_tok;
        end
    end

    // Carry the candidate length along with the wavefront
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= i_len;
        end
    end

    assign o_tok = r_tok;
    assign o_len = r_len;

endmodule

// ----- rtl/edit_distance_engine.sv -----
// Top level of the edit distance engine: config registers, column zero, cell chain, result.
//
//  channel   direction  handshake                        payload
//  in        input      i_in_valid / o_in_stall          i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_stall        o_out_item (t_out_item)
//  cfg       input      i_cfg_we                         i_cfg_index, i_cfg_data
//
// Unless the chain is halted, one item enters per cycle and moves one cell per cycle;
// the result of a marked item passes column zero, QUERY_MAX cells and the output register.
// The whole chain advances as one; it halts while a result waits under i_out_stall,
// and o_in_stall is raised for exactly those cycles.
// Reset is synchronous: cells return to their column index, counters clear.
module edit_distance_engine #(
    parameter int QUERY_MAX     = 20,
    parameter int CANDIDATE_MAX = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ede_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ede_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [ede_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ede_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ede_pkg::*;

    localparam int LEN_W = $clog2(CANDIDATE_MAX + 1);

    logic [63:0] r_qlow;
    logic [63:0] r_qmid;
    logic [31:0] r_qhigh;
    logic [4:0]  r_qlen;
    logic [QUERY_CHARS*8-1:0] w_qvec;
    logic [4:0]  w_msel;

    logic        w_en;
    logic        w_accept;
    logic        w_adv;
    t_cell       r_col0;
    t_cell       w_col0_new;
    logic [LEN_W-1:0] r_cnt;
    logic        r_ovf;
    t_token      r_tok0;
    t_token      n_tok0;
    logic [LEN_W-1:0] r_len0;
    logic [LEN_W-1:0] n_len0;

    t_token           w_tok [0:QUERY_MAX];
    logic [LEN_W-1:0] w_len [0:QUERY_MAX];
    logic [LEN_W+3:0] w_len_ext;

    logic        r_out_valid;
    t_out_item   r_out_item;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlow  <= '0;
            r_qmid  <= '0;
            r_qhigh <= '0;
            r_qlen  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUERY_LOW:  r_qlow  <= i_cfg_data;
                CFG_QUERY_MID:  r_qmid  <= i_cfg_data;
                CFG_QUERY_HIGH: r_qhigh <= i_cfg_data[31:0];
                CFG_QUERY_LEN:  r_qlen  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign w_qvec = {r_qhigh, r_qmid, r_qlow};
    assign w_msel = (r_qlen > 5'(QUERY_MAX)) ? 5'(QUERY_MAX) : r_qlen;

    // Advance the chain unless a finished result is held
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;

    // Column zero and the candidate counter
    assign w_adv      = i_in_item.char_present && (r_cnt < LEN_W'(CANDIDATE_MAX));
    assign w_col0_new = w_adv ? sat_inc(r_col0) : r_col0;

    always_comb begin
        n_tok0.valid = w_accept && (w_adv || i_in_item.last_char);
        n_tok0.adv   = w_adv;
        n_tok0.last  = i_in_item.last_char;
        n_tok0.ovf   = r_ovf || (i_in_item.char_present && !w_adv);
        n_tok0.ch    = i_in_item.candidate_char;
        n_tok0.left  = w_col0_new;
        n_tok0.diag  = r_col0;
        n_tok0.pick  = (w_msel == 5'd0) ? w_col0_new : '0;
        n_len0       = r_cnt + LEN_W'(w_adv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col0       <= '0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_tok0.valid <= 1'b0;
        end else if (w_en) begin
            r_tok0 <= n_tok0;
            if (w_accept) begin
                if (i_in_item.last_char) begin
                    r_col0 <= '0;
                    r_cnt  <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_col0 <= w_col0_new;
                    r_cnt  <= n_len0;
                    r_ovf  <= n_tok0.ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_len0 <= n_len0;
        end
    end

    assign w_tok[0] = r_tok0;
    assign w_len[0] = r_len0;

    // Chain of column cells
    for (genvar k = 1; k <= QUERY_MAX; k++) begin : g_cell
        logic [7:0] w_qchar;
        if (k - 1 < QUERY_CHARS) begin : g_reg_char
            assign w_qchar = w_qvec[(k-1)*8 +: 8];
        end else begin : g_zero_char
            assign w_qchar = 8'h00;
        end

        ede_cell #(
            .COL   (k),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[k-1]),
            .i_len   (w_len[k-1]),
            .i_qchar (w_qchar),
            .i_sel   (w_msel == 5'(k)),
            .o_tok   (w_tok[k]),
            .o_len   (w_len[k])
        );
    end

    // Capture the result at the end of the chain
    assign w_len_ext = {4'b0000, w_len[QUERY_MAX]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tok[QUERY_MAX].valid && w_tok[QUERY_MAX].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item.distance         <= w_tok[QUERY_MAX].pick;
            r_out_item.candidate_length <= w_len_ext[3:0];
            r_out_item.too_long         <= w_tok[QUERY_MAX].ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- rtl/ede_checker.sv -----
// Port-level checks of the edit distance engine, bound to its top level.
module ede_checker #(
    parameter int CANDIDATE_MAX = 8
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ede_pkg::t_out_item o_out_item
);
    import ede_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Refuse items while a result is held
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("item accepted while result held");

    // Clear the output after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Flag overflow only on a full-length candidate
    a_overflow_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.too_long |->
            o_out_item.candidate_length == 4'(CANDIDATE_MAX))
        else $error("overflow with short candidate");

endmodule

bind edit_distance_engine ede_checker #(
    .CANDIDATE_MAX (CANDIDATE_MAX)
) u_ede_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- tb/edit_distance_engine_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the edit distance engine: per-candidate distance prediction and result checks.
module edit_distance_engine_tb;
    import ede_pkg::*;

    localparam int QMAX = 20;
    localparam int CMAX = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 120;
    localparam int PHASE_ITEMS = 280;

    typedef logic [7:0] t_byte;
    typedef t_byte t_byte_q[$];

    // Distance predictor and queue of pending distance results
    class distance_board;
        logic [63:0] chars_low;
        logic [63:0] chars_mid;
        logic [31:0] chars_high;
        logic [4:0]  query_len;
        t_cell       row [QMAX+1];
        int          chars_used;
        bit          overflow;
        t_out_item   expected[$];
        int          errors;
        int          results_seen;

        function new();
            chars_low  = '0;
            chars_mid  = '0;
            chars_high = '0;
            query_len  = '0;
            errors = 0;
            results_seen = 0;
            clear_row();
        endfunction

        function void clear_row();
            for (int j = 0; j <= QMAX; j++) begin
                row[j] = (j > CELL_MAX) ? CELL_MAX : t_cell'(j);
            end
            chars_used = 0;
            overflow = 1'b0;
        endfunction

        function t_cell step_up(t_cell v);
            return (v >= CELL_MAX) ? CELL_MAX : v + t_cell'(1);
        endfunction

        function t_byte query_byte(int pos);
            if (pos < 8) return chars_low[8*pos +: 8];
            if (pos < 16) return chars_mid[8*(pos-8) +: 8];
            if (pos < 20) return chars_high[8*(pos-16) +: 8];
            return 8'h00;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_QUERY_LOW:  chars_low = data;
                CFG_QUERY_MID:  chars_mid = data;
                CFG_QUERY_HIGH: chars_high = data[31:0];
                CFG_QUERY_LEN:  query_len = data[4:0];
                default: ;
            endcase
        endfunction

        // Advance the row by one candidate character
        function void advance_row(t_byte ch);
            t_cell diag, up, best, left, sub;
            diag = row[0];
            row[0] = step_up(row[0]);
            for (int j = 1; j <= QMAX; j++) begin
                up = row[j];
                best = step_up(up);
                left = step_up(row[j-1]);
                sub = (query_byte(j - 1) == ch) ? diag : step_up(diag);
                if (left < best) best = left;
                if (sub < best) best = sub;
                row[j] = best;
                diag = up;
            end
        endfunction

        function void note_input(t_in_item it);
            t_out_item want;
            int col;
            if (it.char_present) begin
                if (chars_used < CMAX) begin
                    advance_row(it.candidate_char);
                    chars_used++;
                end else begin
                    overflow = 1'b1;
                end
            end
            if (!it.last_char) return;
            col = (query_len > QMAX) ? QMAX : int'(query_len);
            want.distance = row[col];
            want.candidate_length = 4'(chars_used);
            want.too_long = overflow;
            expected.push_back(want);
            clear_row();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected.size() == 0) begin
                report($sformatf("result with nothing pending: dist %0d len %0d too_long %0d",
                                 got.distance, got.candidate_length, got.too_long));
                return;
            end
            want = expected.pop_front();
            if (got.distance !== want.distance)
                report($sformatf("distance %0d, expected %0d", got.distance, want.distance));
            if (got.candidate_length !== want.candidate_length)
                report($sformatf("candidate_length %0d, expected %0d",
                                 got.candidate_length, want.candidate_length));
            if (got.too_long !== want.too_long)
                report($sformatf("too_long %0d, expected %0d", got.too_long, want.too_long));
        endtask

        task finish_check();
            while (expected.size() != 0) begin
                void'(expected.pop_front());
                report("expected result never arrived");
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_in_item               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_QUERY_LOW;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    distance_board board;
    int idle_pct = 0;
    int stall_cycles = 0;
    int items_sent = 0;
    int candidates = 0;
    int configs = 0;

    edit_distance_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Offer one item, with an optional idle burst first, and hold it until accepted
    task automatic send_item(input t_in_item it);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            in_item <= t_in_item'($urandom);
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) begin
            stall_cycles++;
            @(posedge clk);
        end
        board.note_input(it);
        if (it.char_present || it.last_char) items_sent++;
    endtask

    // Send one candidate; an empty list or tail_empty ends it with a marked item without char
    task automatic send_candidate(input t_byte_q chars, input bit tail_empty,
                                  input int noise_pct);
        t_in_item it;
        candidates++;
        foreach (chars[i]) begin
            if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) begin
                it = t_in_item'($urandom);
                it.char_present = 1'b0;
                it.last_char = 1'b0;
                send_item(it);
            end
            it.candidate_char = chars[i];
            it.char_present = 1'b1;
            it.last_char = (i == chars.size() - 1) && !tail_empty;
            send_item(it);
        end
        if (chars.size() == 0 || tail_empty) begin
            it.candidate_char = t_byte'($urandom);
            it.char_present = 1'b0;
            it.last_char = 1'b1;
            send_item(it);
        end
    endtask

    // Random candidate, mostly built from query bytes so that matches happen
    task automatic send_random_candidate();
        t_byte_q chars;
        int len, roll, active, pos;
        bit copy_query;
        active = (board.query_len > QMAX) ? QMAX : int'(board.query_len);
        roll = $urandom_range(0, 99);
        if (roll < 8) len = 0;
        else if (roll < 85) len = $urandom_range(1, CMAX);
        else len = $urandom_range(CMAX + 1, CMAX + 4);
        copy_query = ($urandom_range(0, 99) < 15);
        for (int i = 0; i < len; i++) begin
            if (copy_query && ($urandom_range(0, 9) != 0)) begin
                chars.push_back(board.query_byte(i % QMAX));
            end else if ($urandom_range(0, 99) < 65) begin
                pos = $urandom_range(0, ((active > 0) ? active : QMAX) - 1);
                chars.push_back(board.query_byte(pos));
            end else begin
                chars.push_back(t_byte'($urandom));
            end
        end
        send_candidate(chars, ($urandom_range(0, 4) == 0),
                       ($urandom_range(0, 1) == 0) ? 0 : 10);
    endtask

    // Write all query registers; the block is idle when this is called
    task automatic program_query(input logic [63:0] low, input logic [63:0] mid,
                                 input logic [63:0] high, input logic [63:0] len);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_QUERY_LOW, CFG_QUERY_MID, CFG_QUERY_HIGH, CFG_QUERY_LEN};
        vals = '{low, mid, high, len};
        for (int r = 0; r < 4; r++) begin
            cfg_we <= 1'b1;
            cfg_index <= regs[r];
            cfg_data <= vals[r];
            @(posedge clk);
            board.write_reg(regs[r], vals[r]);
        end
        cfg_we <= 1'b0;
        configs++;
    endtask

    // Drop valid, wait for all results, then let ignored items leave the chain
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: check accepted results, stall in random bursts plus one long hold
    initial begin : result_sink
        int hold_left;
        int burst_left;
        bit long_done;
        hold_left = 0;
        burst_left = 0;
        long_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) board.check_result(out_item);
            if (!long_done && board.results_seen >= 40) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                out_stall <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                burst_left = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Timeout: results still pending");
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_byte_q dq;
        logic [159:0] qbits;
        int qlen;
        int target;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: query with bytes 0x00 and 0xFF at the front, full length
        program_query(64'h6E65_7474_696B_FF00, 64'h0102_0304_0506_0708,
                      64'hFFFF_FFFF_A5A5_5A5A, 64'hFFFF_FFFF_FFFF_FFF4);
        dq = {};
        send_candidate(dq, 1'b0, 0);
        dq = {8'h00};
        send_candidate(dq, 1'b0, 100);
        dq = {8'hFF};
        send_candidate(dq, 1'b1, 0);
        dq = {8'h00, 8'hFF, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h65, 8'h6E};
        send_candidate(dq, 1'b0, 0);
        // over-length candidate: the last two characters are dropped
        dq = {8'h00, 8'hFF, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h65, 8'h6E, 8'hAA, 8'h55};
        send_candidate(dq, 1'b0, 0);
        drain();

        // Query length above the column count selects the last column
        program_query(64'h6E65_7474_696B_FF00, 64'h0102_0304_0506_0708,
                      64'h0000_0000_A5A5_5A5A, 64'd31);
        dq = {};
        send_candidate(dq, 1'b0, 0);
        dq = {8'h6B};
        send_candidate(dq, 1'b0, 0);
        drain();

        // Empty query: distance equals the candidate length
        program_query(64'h0, 64'h0, 64'h0, 64'h0);
        dq = {8'h41};
        send_candidate(dq, 1'b0, 0);
        drain();

        // Random phases, each with its own query setting
        for (int p = 0; p < 6; p++) begin
            qbits = {$urandom, $urandom, $urandom, $urandom, $urandom};
            case (p)
                0: begin qlen = $urandom_range(1, QMAX); idle_pct = 20; end
                1: begin qbits = '0; qlen = 0; idle_pct = 10; end
                2: begin qbits = '1; qlen = QMAX; idle_pct = 30; end
                3: begin qlen = 31; idle_pct = 0; end
                4: begin
                    for (int i = 0; i < 20; i++)
                        qbits[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 3));
                    qlen = $urandom_range(1, QMAX);
                    idle_pct = 15;
                end
                default: begin qlen = $urandom_range(0, QMAX); idle_pct = 0; end
            endcase
            program_query(qbits[63:0], qbits[127:64], {32'($urandom), qbits[159:128]},
                          {27'($urandom), 32'($urandom), 5'(qlen)});
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_random_candidate();
            drain();
        end

        board.finish_check();
        $display("Checked %0d distances from %0d candidates (%0d items) over %0d query settings",
                 board.results_seen, candidates, items_sent, configs);
        $display("Input was held off for %0d cycles by output backpressure", stall_cycles);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
